// ===== design/swdfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swdfe_pkg
// Shared types and constants for the single-wire debug frame encoder.
// ----------------------------------------------------------------------------
package swdfe_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_CMD    = 2'd0,
		OP_HOST   = 2'd1,
		OP_TARGET = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	// frame sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_DATA,
		ST_PAR,
		ST_ACK
	} state_t;

	localparam int unsigned PHASE_W = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned CNT_W   = 3;

	localparam logic [PHASE_W-1:0] LONG_NORMAL = PHASE_W'(20);
	localparam logic [PHASE_W-1:0] LONG_FAST   = PHASE_W'(8);
	localparam logic [PHASE_W-1:0] SHORT_PHASE = PHASE_W'(2);

	// payload bit count minus one, loaded into the bit counter
	localparam logic [CNT_W-1:0] CMD_CNT  = CNT_W'(CMD_W - 1);
	localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(BYTE_W - 1);

endpackage
`default_nettype wire

// ===== design/single_wire_debug_frame_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_debug_frame_encoder
// Serialises command and byte frames into pulse-width-coded bit results.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in the idle state into the sequencer state;
//   each bit then goes into the output register, and further bits follow
//   while the output does not stall. A command frame sends a header bit,
//   three payload bits, parity and the ack bit; a byte frame eight payload
//   bits. Opcode 3 is taken and dropped in the idle state. Input stalls
//   while a frame is sent.
// Reset: arst_n clears the sequencer, the output valid and high_speed.
// ----------------------------------------------------------------------------
module single_wire_debug_frame_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	// request channel
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  value,
	// bit result channel
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        bit_value,
	output      logic [4:0]  low_cycles,
	output      logic [4:0]  high_cycles,
	output      logic        last
);

	// configuration register
	logic high_speed_q;

	// sequencer state
	swdfe_pkg::state_t                   state_q, state_d;
	logic                                hdr_q;      // header bit (1 = target)
	logic [swdfe_pkg::BYTE_W-1:0]        sh_q;       // payload, MSB goes next
	logic [swdfe_pkg::CNT_W-1:0]         cnt_q;      // payload bits left minus one
	logic                                par_q;      // running parity

	// output register
	logic                                out_valid_q;
	logic                                bit_q;
	logic                                last_q;
	logic [swdfe_pkg::PHASE_W-1:0]       low_q, high_q;

	// combinational
	logic                                in_take;
	logic                                adv;        // output slot free this cycle
	logic                                emit;       // sequencer puts a bit out
	logic                                nbit;
	logic                                nlast;
	logic [swdfe_pkg::PHASE_W-1:0]       long_t;
	swdfe_pkg::op_t                      op_in;

	assign op_in    = swdfe_pkg::op_t'(op);
	assign in_stall = (state_q != swdfe_pkg::ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign adv      = !out_valid_q || !out_stall;
	assign long_t   = high_speed_q ? swdfe_pkg::LONG_FAST : swdfe_pkg::LONG_NORMAL;

	// next bit and next state
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		nbit    = 1'b0;
		nlast   = 1'b0;
		case (state_q)
			swdfe_pkg::ST_IDLE: begin
				if (in_take) begin
					case (op_in)
						swdfe_pkg::OP_CMD,
						swdfe_pkg::OP_HOST,
						swdfe_pkg::OP_TARGET: state_d = swdfe_pkg::ST_HEAD;
						default:              state_d = swdfe_pkg::ST_IDLE;
					endcase
				end
			end
			swdfe_pkg::ST_HEAD: begin
				emit = adv;
				nbit = hdr_q;
				if (adv) state_d = swdfe_pkg::ST_DATA;
			end
			swdfe_pkg::ST_DATA: begin
				emit = adv;
				nbit = sh_q[swdfe_pkg::BYTE_W-1];
				if (adv && cnt_q == '0) state_d = swdfe_pkg::ST_PAR;
			end
			swdfe_pkg::ST_PAR: begin
				emit = adv;
				nbit = par_q;
				if (adv) state_d = swdfe_pkg::ST_ACK;
			end
			swdfe_pkg::ST_ACK: begin
				emit  = adv;
				nbit  = 1'b1;
				nlast = 1'b1;
				if (adv) state_d = swdfe_pkg::ST_IDLE;
			end
			default: state_d = swdfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swdfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_speed_q <= 1'b0;
		end else if (cfg_we) begin
			high_speed_q <= cfg_wdata;
		end
	end

	// payload shifter, bit counter and parity
	always_ff @(posedge clk) begin
		if (in_take) begin
			hdr_q <= (op_in == swdfe_pkg::OP_TARGET);
			par_q <= 1'b0;
			if (op_in == swdfe_pkg::OP_CMD) begin
				sh_q  <= {value[swdfe_pkg::CMD_W-1:0],
					{(swdfe_pkg::BYTE_W - swdfe_pkg::CMD_W){1'b0}}};
				cnt_q <= swdfe_pkg::CMD_CNT;
			end else begin
				sh_q  <= value;
				cnt_q <= swdfe_pkg::BYTE_CNT;
			end
		end else if (state_q == swdfe_pkg::ST_DATA && adv) begin
			sh_q  <= {sh_q[swdfe_pkg::BYTE_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			par_q <= par_q ^ sh_q[swdfe_pkg::BYTE_W-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bit_q  <= nbit;
			last_q <= nlast;
			low_q  <= nbit ? swdfe_pkg::SHORT_PHASE : long_t;
			high_q <= nbit ? long_t : swdfe_pkg::SHORT_PHASE;
		end
	end

	assign out_valid   = out_valid_q;
	assign bit_value   = bit_q;
	assign last        = last_q;
	assign low_cycles  = low_q;
	assign high_cycles = high_q;

	// checks
	a_last_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> bit_q)
		else $error("ack bit not a one");

	a_short_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bit_q ? (low_q == swdfe_pkg::SHORT_PHASE)
		                       : (high_q == swdfe_pkg::SHORT_PHASE)))
		else $error("pulse timing does not match bit value");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && (op_in == swdfe_pkg::OP_HOST || op_in == swdfe_pkg::OP_TARGET ||
		            op_in == swdfe_pkg::OP_CMD)
		|=> state_q == swdfe_pkg::ST_HEAD)
		else $error("frame not started after request");

	a_ack_closes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swdfe_pkg::ST_ACK && adv |=> out_valid_q && last_q &&
		state_q == swdfe_pkg::ST_IDLE)
		else $error("ack bit not delivered at frame end");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - single_wire_debug_frame_encoder testbench
// Drives command, host and target requests and compares every serialised
// bit (value, low phase, high phase, ack flag) against a local predictor.
// Runs directed edge cases and then random traffic. Both speed settings are
// covered, with a range of sender gaps and receiver stalls and two long
// output holds that back the block up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SETTLE_CYCLES = 4;    // margin after the last bit before idle
	localparam int unsigned HOLD_LEN      = 200;  // long receiver hold-off
	localparam int unsigned WDOG_LIMIT    = 2000; // quiet cycles before giving up
	localparam int unsigned RAND_FRAMES   = 47;   // frames per random phase

	// one transmitted bit as seen on the result channel
	typedef struct packed {
		logic       bit_value;
		logic [4:0] low_cycles;
		logic [4:0] high_cycles;
		logic       last;
	} line_bit_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cfg_we    = 1'b0;
	logic           cfg_wdata = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_stall;
	swdfe_pkg::op_t op        = swdfe_pkg::OP_CMD;
	logic [7:0]     value     = 8'h00;
	logic           out_valid;
	logic           out_stall = 1'b0;
	logic           bit_value;
	logic [4:0]     low_cycles;
	logic [4:0]     high_cycles;
	logic           last;

	// expected line bits, oldest first
	line_bit_t  pending_bits[$];
	// local copy of the speed register
	logic       fast_mode = 1'b0;

	int         fail_count     = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	logic       hold_req       = 1'b0;
	int         quiet_cycles   = 0;

	single_wire_debug_frame_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bit_value   (bit_value),
		.low_cycles  (low_cycles),
		.high_cycles (high_cycles),
		.last        (last)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Pulse-width coding: a zero is long low then short high, a one the reverse.
	function automatic void push_line_bit(logic b, logic is_ack);
		line_bit_t  e;
		logic [4:0] long_ph;
		long_ph       = fast_mode ? swdfe_pkg::LONG_FAST : swdfe_pkg::LONG_NORMAL;
		e.bit_value   = b;
		e.low_cycles  = b ? swdfe_pkg::SHORT_PHASE : long_ph;
		e.high_cycles = b ? long_ph : swdfe_pkg::SHORT_PHASE;
		e.last        = is_ack;
		pending_bits.push_back(e);
	endfunction

	// Header, payload MSB first, even parity over the payload, then the ack bit.
	function automatic void predict_frame(swdfe_pkg::op_t o, logic [7:0] v);
		int         nbits;
		logic [7:0] payload;
		logic       par;
		case (o)
			swdfe_pkg::OP_CMD: begin
				push_line_bit(1'b0, 1'b0);
				nbits   = swdfe_pkg::CMD_W;
				payload = {5'b0, v[2:0]};   // upper bits play no part in a command
			end
			swdfe_pkg::OP_HOST: begin
				push_line_bit(1'b0, 1'b0);
				nbits   = swdfe_pkg::BYTE_W;
				payload = v;
			end
			swdfe_pkg::OP_TARGET: begin
				push_line_bit(1'b1, 1'b0);
				nbits   = swdfe_pkg::BYTE_W;
				payload = v;
			end
			default: return;                // reserved opcode: dropped, no bits
		endcase
		par = 1'b0;
		for (int i = nbits - 1; i >= 0; i--) begin
			push_line_bit(payload[i], 1'b0);
			par ^= payload[i];
		end
		push_line_bit(par, 1'b0);
		push_line_bit(1'b1, 1'b1);
	endfunction

	// ------------------------------------------------------------------------
	// Result checking: every bit taken off the output is matched in order
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		line_bit_t exp_bit;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bits.size() == 0) begin
				$error("bit result with nothing expected: bit_value %0d last %0d",
					bit_value, last);
				fail_count++;
			end else begin
				exp_bit = pending_bits.pop_front();
				check_field("bit_value",   exp_bit.bit_value,   bit_value);
				check_field("low_cycles",  exp_bit.low_cycles,  low_cycles);
				check_field("high_cycles", exp_bit.high_cycles, high_cycles);
				check_field("last",        exp_bit.last,        last);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off when the pressure test
	// asks for one. At most one assignment to out_stall per clock edge.
	// ------------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with no request or bit accepted means a hang
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
			$display("** single_wire_debug_frame_encoder: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Request driver. Valid stays high across back-to-back requests and is
	// only lowered for a gap or once the sequence is over.
	// ------------------------------------------------------------------------
	task automatic send_req(swdfe_pkg::op_t o, logic [7:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_frame(o, v);
	endtask

	// drop valid, wait for all bits and let the sequencer go idle
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_bits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_speed(logic hs);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= hs;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fast_mode = hs;
	endtask

	function automatic swdfe_pkg::op_t pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return swdfe_pkg::OP_RSVD;
		else if (r < 36)
			return swdfe_pkg::OP_CMD;
		else if (r < 68)
			return swdfe_pkg::OP_HOST;
		else
			return swdfe_pkg::OP_TARGET;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corner values of every opcode, command upper bits, reserved opcode.
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_req(swdfe_pkg::OP_CMD,    8'h00);
		send_req(swdfe_pkg::OP_CMD,    8'h07);
		send_req(swdfe_pkg::OP_CMD,    8'hF8);   // upper bits set, command 0
		send_req(swdfe_pkg::OP_CMD,    8'hFD);   // upper bits set, command 5
		send_req(swdfe_pkg::OP_CMD,    8'h03);
		send_req(swdfe_pkg::OP_HOST,   8'h00);
		send_req(swdfe_pkg::OP_HOST,   8'hFF);
		send_req(swdfe_pkg::OP_HOST,   8'h80);
		send_req(swdfe_pkg::OP_HOST,   8'h01);
		send_req(swdfe_pkg::OP_HOST,   8'hA5);
		send_req(swdfe_pkg::OP_TARGET, 8'h00);
		send_req(swdfe_pkg::OP_TARGET, 8'hFF);
		send_req(swdfe_pkg::OP_TARGET, 8'h5A);
		send_req(swdfe_pkg::OP_TARGET, 8'h7F);
		send_req(swdfe_pkg::OP_RSVD,   8'h00);   // reserved opcode is swallowed
		send_req(swdfe_pkg::OP_RSVD,   8'hFF);
		send_req(swdfe_pkg::OP_CMD,    8'h06);   // nothing leaks from the dropped requests
		send_req(swdfe_pkg::OP_RSVD,   8'h5A);
		send_req(swdfe_pkg::OP_TARGET, 8'h81);
		settle_idle();
	endtask

	// Random frames under one idling pattern; reserved requests not counted.
	task automatic test_random(int s_pct, int r_pct, int n_frames);
		int             sent;
		swdfe_pkg::op_t o;
		sent           = 0;
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		while (sent < n_frames) begin
			o = pick_op();
			send_req(o, 8'($urandom_range(255)));
			if (o != swdfe_pkg::OP_RSVD)
				sent++;
		end
		settle_idle();
	endtask

	// Output held off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (12) send_req(pick_op(), 8'($urandom_range(255)));
		settle_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the speed register is normal speed
		test_directed();
		set_speed(1'b1);
		test_directed();

		set_speed(1'b0);
		test_random(0, 0, RAND_FRAMES);
		set_speed(1'b1);
		test_random(83, 0, RAND_FRAMES);
		set_speed(1'b0);
		test_random(0, 83, RAND_FRAMES);
		set_speed(1'b1);
		test_random(13, 13, RAND_FRAMES);

		test_backpressure();
		set_speed(1'b0);
		test_backpressure();

		settle_idle();
		if (fail_count == 0)
			$display("** single_wire_debug_frame_encoder: PASSED **");
		else
			$display("** single_wire_debug_frame_encoder: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/swdfe_pkg.sv
design/single_wire_debug_frame_encoder.sv
test/tb.sv
